// ===== rtl/tfj_pkg.sv =====
// Shared types and codes for the top-up failure journal.
// Request, response and stored entry layouts; no dependencies.
package tfj_pkg;

    localparam logic [1:0] FUNC_INSERT = 2'd0;
    localparam logic [1:0] FUNC_CLEAR  = 2'd1;
    localparam logic [1:0] FUNC_CHECK  = 2'd2;

    localparam logic [7:0] PENDING_FLAG = 8'h55;
    localparam logic [7:0] CLEARED_FLAG = 8'h00;

    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] card_serial;
        logic [15:0] card_count;
        logic [7:0]  record_pointer;
        logic [7:0]  card_status;
        logic [7:0]  clear_value;
    } t_req;

    typedef struct packed {
        logic        found;
        logic [2:0]  slot;
        logic [15:0] stored_count;
        logic [7:0]  stored_record_pointer;
        logic [7:0]  stored_status;
    } t_rsp;

    typedef struct packed {
        logic [7:0]  flag;
        logic [31:0] serial;
        logic [15:0] count;
        logic [7:0]  record_pointer;
        logic [7:0]  status;
    } t_entry;

endpackage

// ===== rtl/tfj_mem.sv =====
// Journal entry store: one write port, one read port, registered read data.
// Uses t_entry from tfj_pkg.
module tfj_mem #(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_we,
    input  logic [AW-1:0]   i_waddr,
    input  tfj_pkg::t_entry i_wdata,
    input  logic [AW-1:0]   i_raddr,
    output tfj_pkg::t_entry o_rdata
);
    import tfj_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/tfj_ctrl.sv =====
// Journal sequencer: ring pointers, insert, clear and check walks over the store.
// Uses tfj_pkg types; drives one tfj_mem instance.
module tfj_ctrl #(
    parameter int DEPTH = 8,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_req_valid,
    input  tfj_pkg::t_req   i_req,
    output logic            o_req_stall,
    output logic            o_res_valid,
    output tfj_pkg::t_rsp   o_res,
    input  logic            i_res_take,
    output logic            o_mem_we,
    output logic [AW-1:0]   o_mem_waddr,
    output tfj_pkg::t_entry o_mem_wdata,
    output logic [AW-1:0]   o_mem_raddr,
    input  tfj_pkg::t_entry i_mem_rdata
);
    import tfj_pkg::*;

    localparam int SW = (AW > 3) ? AW : 3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_INS,
        S_WALK,
        S_FIN,
        S_FRD,
        S_DONE
    } t_state;

    t_state        r_state, n_state;
    logic [AW-1:0] r_wr_idx, n_wr_idx;
    logic [AW-1:0] r_old_idx, n_old_idx;
    logic [AW-1:0] r_matched, n_matched;
    logic [AW-1:0] r_rd_idx, n_rd_idx;
    logic [AW-1:0] r_ev_idx, n_ev_idx;
    logic          r_ev_valid, n_ev_valid;
    logic          r_found, n_found;
    t_req          r_req, n_req;
    t_rsp          r_rsp, n_rsp;

    logic          issue;
    logic          hit;
    logic          ev_match;
    logic [AW-1:0] newest;
    logic [AW-1:0] wr_next;
    logic [15:0]   want;
    logic [SW-1:0] slot_ext;

    function automatic logic [AW-1:0] ring_next(input logic [AW-1:0] idx);
        return (idx == AW'(DEPTH - 1)) ? '0 : idx + AW'(1);
    endfunction

    assign newest   = (r_wr_idx == '0) ? AW'(DEPTH - 1) : r_wr_idx - AW'(1);
    assign wr_next  = ring_next(r_wr_idx);
    assign want     = r_req.card_count - 16'd1;
    assign slot_ext = SW'(r_matched);
    assign ev_match = r_ev_valid && (i_mem_rdata.flag == PENDING_FLAG)
                      && (i_mem_rdata.serial == r_req.card_serial);

    always_comb begin
        n_state    = r_state;
        n_wr_idx   = r_wr_idx;
        n_old_idx  = r_old_idx;
        n_matched  = r_matched;
        n_rd_idx   = r_rd_idx;
        n_ev_idx   = r_ev_idx;
        n_ev_valid = r_ev_valid;
        n_found    = r_found;
        n_req      = r_req;
        n_rsp      = r_rsp;
        o_mem_we    = 1'b0;
        o_mem_waddr = r_ev_idx;
        o_mem_wdata = i_mem_rdata;
        issue      = 1'b0;
        hit        = 1'b0;

        case (r_state)
            S_IDLE: begin
                if (i_req_valid) begin
                    n_req      = i_req;
                    n_found    = 1'b0;
                    n_rd_idx   = r_old_idx;
                    n_ev_valid = 1'b0;
                    case (i_req.func)
                        FUNC_INSERT: n_state = S_INS;
                        FUNC_CLEAR:  n_state = S_WALK;
                        FUNC_CHECK:  n_state = S_WALK;
                        default: begin
                            n_rsp   = '0;
                            n_state = S_DONE;
                        end
                    endcase
                end
            end
            S_INS: begin
                o_mem_we    = 1'b1;
                o_mem_waddr = r_wr_idx;
                o_mem_wdata = '{flag: PENDING_FLAG, serial: r_req.card_serial,
                                count: r_req.card_count,
                                record_pointer: r_req.record_pointer,
                                status: r_req.card_status};
                n_wr_idx = wr_next;
                // ring full: drop the oldest entry
                if (r_old_idx == wr_next) begin
                    n_old_idx = ring_next(r_old_idx);
                end
                n_rsp   = '0;
                n_state = S_DONE;
            end
            S_WALK: begin
                // read of r_rd_idx overlaps the write-back of r_ev_idx; never the same slot
                if (r_req.func == FUNC_CHECK) begin
                    if (ev_match) begin
                        n_matched = r_ev_idx;
                        if (i_mem_rdata.count == want) begin
                            hit     = 1'b1;
                            n_found = 1'b1;
                        end
                    end
                end else if (r_ev_valid) begin
                    if (i_mem_rdata.flag != PENDING_FLAG) begin
                        if (r_ev_idx != newest) begin
                            o_mem_we         = 1'b1;
                            o_mem_wdata.flag = CLEARED_FLAG;
                        end
                    end else if (ev_match) begin
                        o_mem_we         = 1'b1;
                        o_mem_wdata.flag = (r_ev_idx != newest) ? CLEARED_FLAG
                                                                : r_req.clear_value;
                    end
                end
                issue      = (r_rd_idx != r_wr_idx) && !hit;
                n_ev_valid = issue;
                n_ev_idx   = r_rd_idx;
                if (issue) begin
                    n_rd_idx = ring_next(r_rd_idx);
                end
                if (hit) begin
                    n_state = S_FIN;
                end else if (!issue && !r_ev_valid) begin
                    if (r_req.func == FUNC_CHECK) begin
                        n_state = S_FIN;
                    end else begin
                        n_rsp   = '0;
                        n_state = S_DONE;
                    end
                end
            end
            S_FIN: begin
                n_state = S_FRD;
            end
            S_FRD: begin
                n_rsp = '{found: r_found, slot: slot_ext[2:0],
                          stored_count: i_mem_rdata.count,
                          stored_record_pointer: i_mem_rdata.record_pointer,
                          stored_status: i_mem_rdata.status};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_take) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_req    <= n_req;
        r_rsp    <= n_rsp;
        r_rd_idx <= n_rd_idx;
        r_ev_idx <= n_ev_idx;
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_wr_idx   <= '0;
            r_old_idx  <= '0;
            r_matched  <= '0;
            r_ev_valid <= 1'b0;
            r_found    <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_wr_idx   <= n_wr_idx;
            r_old_idx  <= n_old_idx;
            r_matched  <= n_matched;
            r_ev_valid <= n_ev_valid;
            r_found    <= n_found;
        end
    end

    assign o_req_stall = (r_state != S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_rsp;
    assign o_mem_raddr = (r_state == S_FIN) ? r_matched : r_rd_idx;

    a_we_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_mem_we |-> (r_state == S_INS) || (r_state == S_WALK))
        else $error("store written outside insert or walk");

    a_ring_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_INS) |=> (r_wr_idx != r_old_idx))
        else $error("insert left the ring looking empty");

    a_eval_in_walk: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev_valid |-> (r_state == S_WALK))
        else $error("pending entry evaluation outside walk");

    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_idx <= AW'(DEPTH - 1)) && (r_old_idx <= AW'(DEPTH - 1)))
        else $error("ring pointer beyond depth");

endmodule

// ===== rtl/topup_fail_journal.sv =====
// Top level of the top-up failure journal: sequencer, entry store, result register.
// Depends on tfj_pkg, tfj_mem and tfj_ctrl.
//
//  channel   valid        stall        payload
//  request   i_in_valid   o_in_stall   i_in  (tfj_pkg::t_req)
//  result    o_out_valid  i_out_stall  o_out (tfj_pkg::t_rsp)
//
// One request at a time, each gives one result. The ring holds fewer than DEPTH live
// entries; clear and check walk them, reading one entry per cycle through the single
// store read port.
// Reset clears the ring pointers; entry contents are not cleared.
// A stalled result sits in the output register while the next request runs.
module topup_fail_journal #(
    parameter int DEPTH = 8
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_stall,
    input  tfj_pkg::t_req i_in,
    output logic          o_out_valid,
    input  logic          i_out_stall,
    output tfj_pkg::t_rsp o_out
);
    import tfj_pkg::*;

    localparam int AW = $clog2(DEPTH);

    logic          res_valid;
    logic          res_take;
    t_rsp          res;
    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    logic [AW-1:0] mem_raddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;

    logic          r_out_valid;
    t_rsp          r_out;

    tfj_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_in_valid),
        .i_req       (i_in),
        .o_req_stall (o_in_stall),
        .o_res_valid (res_valid),
        .o_res       (res),
        .i_res_take  (res_take),
        .o_mem_we    (mem_we),
        .o_mem_waddr (mem_waddr),
        .o_mem_wdata (mem_wdata),
        .o_mem_raddr (mem_raddr),
        .i_mem_rdata (mem_rdata)
    );

    tfj_mem #(.DEPTH(DEPTH)) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign res_take = res_valid && (!r_out_valid || !i_out_stall);

    always_ff @(posedge i_clk) begin
        if (res_take) begin
            r_out <= res;
        end
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_take) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

endmodule
